// File: src/uv1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv1_pkg: shared types and constants for the version 1 uuid generator
// field widths, mode and status codes, register map, result packing
// ----------------------------------------------------------------------------
package uv1_pkg;

    localparam int STAMP_W = 60;
    localparam int SEQ_W   = 14;
    localparam int NODE_W  = 48;

    // apb register map: one 64-bit register at byte address 0
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_NODE_ID = 1'b0;

    // request modes
    localparam logic [1:0] MODE_GEN  = 2'd0;
    localparam logic [1:0] MODE_INIT = 2'd1;
    localparam logic [1:0] MODE_SET  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_UUID    = 2'd0;
    localparam logic [1:0] STATUS_RETRY   = 2'd1;
    localparam logic [1:0] STATUS_APPLIED = 2'd2;

    localparam logic [3:0] UUID_VERSION = 4'h1;
    localparam logic [1:0] UUID_VARIANT = 2'b10;
    localparam logic [NODE_W-1:0] NODE_MCAST = 48'h0100_0000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [STAMP_W-1:0] time_reading;
        logic [SEQ_W-1:0]   seed;
    } uv1_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       stamp_low;
        logic [15:0]       stamp_mid;
        logic [15:0]       stamp_high_version;
        logic [7:0]        seq_high_variant;
        logic [7:0]        seq_low;
        logic [NODE_W-1:0] node_out;
    } uv1_result_t;

endpackage

// File: src/uv1_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv1_req_if: request channel
// valid/ready handshake carrying mode, clock reading and seed
// ----------------------------------------------------------------------------
interface uv1_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [uv1_pkg::STAMP_W-1:0] time_reading;
    logic [uv1_pkg::SEQ_W-1:0]   seed;

    modport source (output valid, output mode, output time_reading, output seed,
                    input ready);
    modport sink   (input valid, input mode, input time_reading, input seed,
                    output ready);
endinterface

// File: src/uv1_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv1_rsp_if: result channel
// valid/ready handshake carrying status and the packed uuid fields
// ----------------------------------------------------------------------------
interface uv1_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [31:0]                stamp_low;
    logic [15:0]                stamp_mid;
    logic [15:0]                stamp_high_version;
    logic [7:0]                 seq_high_variant;
    logic [7:0]                 seq_low;
    logic [uv1_pkg::NODE_W-1:0] node_out;

    modport source (output valid, output status, output stamp_low, output stamp_mid,
                    output stamp_high_version, output seq_high_variant,
                    output seq_low, output node_out, input ready);
    modport sink   (input valid, input status, input stamp_low, input stamp_mid,
                    input stamp_high_version, input seq_high_variant,
                    input seq_low, input node_out, output ready);
endinterface

// File: src/uv1_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv1_apb_regs: configuration register file
// apb slave holding the 48-bit node identifier
// ----------------------------------------------------------------------------
module uv1_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uv1_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uv1_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uv1_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [uv1_pkg::NODE_W-1:0]      node_id
);

    logic [uv1_pkg::NODE_W-1:0] node_id_reg;
    logic [uv1_pkg::NODE_W-1:0] node_id_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register select is the 8-byte word address
    always_comb
    begin
        node_id_next = node_id_reg;
        prdata       = '0;
        unique case (paddr[3])
            uv1_pkg::REG_NODE_ID:
            begin
                prdata = uv1_pkg::APB_DATA_W'(node_id_reg);
                if (wr_en)
                begin
                    node_id_next = pwdata[uv1_pkg::NODE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
        end
        else
        begin
            node_id_reg <= node_id_next;
        end
    end

    assign node_id = node_id_reg;

endmodule

// File: src/uv1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv1_core: stamp and clock sequence engine
// holds the generator state and builds one result per enabled item
// ----------------------------------------------------------------------------
module uv1_core #(
    parameter int TICK_LIMIT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  uv1_pkg::uv1_item_t          item,
    input  logic [uv1_pkg::NODE_W-1:0]  node_id,
    output uv1_pkg::uv1_result_t        result
);

    localparam int TICK_W = $clog2(TICK_LIMIT + 1);
    localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'(TICK_LIMIT);

    logic [uv1_pkg::STAMP_W-1:0] last_reading_reg, last_reading_next;
    logic [TICK_W-1:0]           tick_count_reg, tick_count_next;
    logic [uv1_pkg::STAMP_W-1:0] saved_stamp_reg, saved_stamp_next;
    logic [uv1_pkg::SEQ_W-1:0]   seq_count_reg, seq_count_next;

    logic                        same_tick;
    logic                        exhausted;
    logic [TICK_W-1:0]           tick_bump;
    logic [uv1_pkg::STAMP_W-1:0] stamp;

    always_comb
    begin
        same_tick = (item.time_reading == last_reading_reg);
        exhausted = same_tick && (tick_count_reg == TICK_MAX);
        tick_bump = same_tick ? TICK_W'(tick_count_reg + 1'b1) : '0;
        // wraps modulo 2^60
        stamp     = item.time_reading + uv1_pkg::STAMP_W'(tick_bump);

        last_reading_next = last_reading_reg;
        tick_count_next   = tick_count_reg;
        saved_stamp_next  = saved_stamp_reg;
        seq_count_next    = seq_count_reg;

        result        = '0;
        result.status = uv1_pkg::STATUS_APPLIED;

        unique case (item.mode)
            uv1_pkg::MODE_GEN:
            begin
                if (exhausted)
                begin
                    result.status = uv1_pkg::STATUS_RETRY;
                end
                else
                begin
                    last_reading_next = item.time_reading;
                    tick_count_next   = tick_bump;
                    saved_stamp_next  = stamp;
                    // clock went backwards
                    if (stamp < saved_stamp_reg)
                    begin
                        seq_count_next = uv1_pkg::SEQ_W'(seq_count_reg + 1'b1);
                    end
                    result.status             = uv1_pkg::STATUS_UUID;
                    result.stamp_low          = stamp[31:0];
                    result.stamp_mid          = stamp[47:32];
                    result.stamp_high_version = {uv1_pkg::UUID_VERSION, stamp[59:48]};
                    result.seq_high_variant   = {uv1_pkg::UUID_VARIANT,
                                                 seq_count_next[13:8]};
                    result.seq_low            = seq_count_next[7:0];
                    result.node_out           = node_id | uv1_pkg::NODE_MCAST;
                end
            end
            uv1_pkg::MODE_INIT:
            begin
                if (exhausted)
                begin
                    result.status = uv1_pkg::STATUS_RETRY;
                end
                else
                begin
                    last_reading_next = item.time_reading;
                    tick_count_next   = tick_bump;
                    saved_stamp_next  = stamp;
                    seq_count_next    = item.seed;
                end
            end
            uv1_pkg::MODE_SET:
            begin
                saved_stamp_next = item.time_reading;
            end
            default:
            begin
                // undefined mode leaves the state alone
                result.status = uv1_pkg::STATUS_APPLIED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reading_reg <= '0;
            tick_count_reg   <= TICK_MAX;
            saved_stamp_reg  <= '0;
            seq_count_reg    <= '0;
        end
        else if (en)
        begin
            last_reading_reg <= last_reading_next;
            tick_count_reg   <= tick_count_next;
            saved_stamp_reg  <= saved_stamp_next;
            seq_count_reg    <= seq_count_next;
        end
    end

endmodule

// File: src/uuid_v1_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_v1_generator: version 1 uuid generator
// turns 60-bit clock readings into time-based uuids with per-tick counter,
// clock sequence tracking and an apb node identifier register
// ----------------------------------------------------------------------------
// a request transfer lands in the input register, and its result passes to the output register before rsp offers it
// throughput: one request per cycle while rsp takes results; uv1_core updates its state as each item moves on
// an input register and an output register split the two channels, so a new
// request is taken while a finished result still waits on rsp
// reset: asynchronous, active low; clears the valid flags of both stages, the node register,
// stamps and clock sequence, and loads the tick counter with its limit
module uuid_v1_generator #(
    parameter int TICK_LIMIT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    uv1_req_if.sink                         req,
    uv1_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uv1_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uv1_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uv1_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [uv1_pkg::NODE_W-1:0] node_id;

    // input stage
    logic                 in_valid_reg, in_valid_next;
    uv1_pkg::uv1_item_t   in_item_reg;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    uv1_pkg::uv1_result_t out_data_reg;

    uv1_pkg::uv1_result_t core_result;
    logic                 req_xfer;
    logic                 advance;

    // configuration register
    uv1_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .node_id (node_id)
    );

    // item moves from the input register into the output register when
    // the output register is empty or its result is being taken
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    // state is updated in the same cycle the item moves on
    uv1_core #(
        .TICK_LIMIT (TICK_LIMIT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .item    (in_item_reg),
        .node_id (node_id),
        .result  (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            in_item_reg.mode         <= req.mode;
            in_item_reg.time_reading <= req.time_reading;
            in_item_reg.seed         <= req.seed;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_data_reg.status;
    assign rsp.stamp_low          = out_data_reg.stamp_low;
    assign rsp.stamp_mid          = out_data_reg.stamp_mid;
    assign rsp.stamp_high_version = out_data_reg.stamp_high_version;
    assign rsp.seq_high_variant   = out_data_reg.seq_high_variant;
    assign rsp.seq_low            = out_data_reg.seq_low;
    assign rsp.node_out           = out_data_reg.node_out;

    // a request transfer always lands in the input register
    a_req_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> in_valid_reg)
        else $error("request transfer lost before input register");

    // a waiting item must move on whenever the output side frees up
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input register held while output register empty");

    // non-uuid answers carry only a status
    a_non_uuid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != uv1_pkg::STATUS_UUID) |->
            (rsp.stamp_low == '0 && rsp.stamp_mid == '0 && rsp.node_out == '0
             && rsp.seq_low == '0 && rsp.seq_high_variant == '0))
        else $error("non-uuid result carries payload");

    // uuid answers carry version, variant and multicast marks
    a_uuid_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == uv1_pkg::STATUS_UUID) |->
            (rsp.stamp_high_version[15:12] == uv1_pkg::UUID_VERSION
             && rsp.seq_high_variant[7:6] == uv1_pkg::UUID_VARIANT
             && rsp.node_out[40]))
        else $error("uuid result missing version, variant or multicast bit");

endmodule

// File: tb/sv/tb_uuid_v1_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uuid_v1_generator: self-checking bench for the version 1 uuid generator
// drives requests and node id writes, predicts every result in a scoreboard
// class that tracks tick counter, saved stamp and clock sequence, and checks
// each result transfer field by field under random stalls on both channels
// ----------------------------------------------------------------------------
module tb_uuid_v1_generator;
    import uv1_pkg::*;

    localparam int unsigned TICK_LIMIT  = 1024;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = 8;

    // the fourth mode value has no package name; the block treats it as a no-op
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    // node id is register 0; the register is 64 bits wide, so it sits at 8*0
    localparam logic [APB_ADDR_W-1:0] NODE_ID_ADDR = APB_ADDR_W'(8 * int'(REG_NODE_ID));

    localparam logic [STAMP_W-1:0] MAX_READING = '1;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the generator state plus the queue of due uuids
    // ------------------------------------------------------------------------
    class uuid_tracker;
        logic [STAMP_W-1:0] last_reading;
        int unsigned        tick_count;
        logic [STAMP_W-1:0] saved_stamp;
        logic [SEQ_W-1:0]   seq_count;
        logic [NODE_W-1:0]  node_id;
        uv1_result_t        uuid_due[$];
        int unsigned        mismatches;

        function new();
            last_reading = '0;
            tick_count   = TICK_LIMIT;
            saved_stamp  = '0;
            seq_count    = '0;
            node_id      = '0;
            mismatches   = 0;
        endfunction

        function int unsigned pending();
            return uuid_due.size();
        endfunction

        // per-tick counter: a new reading restarts it, a repeat bumps it
        function bit draw_stamp(input logic [STAMP_W-1:0] reading,
                                output logic [STAMP_W-1:0] stamp);
            stamp = '0;
            if (reading != last_reading)
            begin
                tick_count   = 0;
                last_reading = reading;
            end
            else if (tick_count < TICK_LIMIT)
                tick_count++;
            else
                return 1'b0;
            stamp = reading + STAMP_W'(tick_count);
            return 1'b1;
        endfunction

        function uv1_result_t predict_uuid(uv1_item_t req);
            uv1_result_t        res;
            logic [STAMP_W-1:0] stamp;
            res = '0;
            case (req.mode)
                MODE_INIT:
                begin
                    if (!draw_stamp(req.time_reading, stamp))
                        res.status = STATUS_RETRY;
                    else
                    begin
                        saved_stamp = stamp;
                        seq_count   = req.seed;
                        res.status  = STATUS_APPLIED;
                    end
                end
                MODE_SET:
                begin
                    saved_stamp = req.time_reading;
                    res.status  = STATUS_APPLIED;
                end
                MODE_GEN:
                begin
                    if (!draw_stamp(req.time_reading, stamp))
                        res.status = STATUS_RETRY;
                    else
                    begin
                        // clock went backwards: bump the sequence
                        if (stamp < saved_stamp)
                            seq_count = seq_count + 1'b1;
                        saved_stamp            = stamp;
                        res.status             = STATUS_UUID;
                        res.stamp_low          = stamp[31:0];
                        res.stamp_mid          = stamp[47:32];
                        res.stamp_high_version = {UUID_VERSION, stamp[59:48]};
                        res.seq_high_variant   = {UUID_VARIANT, seq_count[13:8]};
                        res.seq_low            = seq_count[7:0];
                        res.node_out           = node_id | NODE_MCAST;
                    end
                end
                default:
                    res.status = STATUS_APPLIED;
            endcase
            return res;
        endfunction

        function void note_request(uv1_item_t req);
            uuid_due.push_back(predict_uuid(req));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_result(uv1_result_t got);
            uv1_result_t want;
            if (uuid_due.size() == 0)
            begin
                report_mismatch($sformatf("result with status %0d and nothing due", got.status));
                return;
            end
            want = uuid_due.pop_front();
            compare_field("status", 64'(got.status), 64'(want.status));
            compare_field("stamp_low", 64'(got.stamp_low), 64'(want.stamp_low));
            compare_field("stamp_mid", 64'(got.stamp_mid), 64'(want.stamp_mid));
            compare_field("stamp_high_version", 64'(got.stamp_high_version),
                          64'(want.stamp_high_version));
            compare_field("seq_high_variant", 64'(got.seq_high_variant),
                          64'(want.seq_high_variant));
            compare_field("seq_low", 64'(got.seq_low), 64'(want.seq_low));
            compare_field("node_out", 64'(got.node_out), 64'(want.node_out));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, channels, apb wires, dut
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    uv1_req_if req_ch();
    uv1_rsp_if rsp_ch();

    uuid_tracker tracker = new();

    // idle odds in percent, set per phase by the main sequence
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // long receiver hold-off, requested by the main sequence
    bit          long_hold_req = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned cycle_count   = 0;

    // last reading offered, so random readings can repeat or step near it
    logic [STAMP_W-1:0] cur_reading = '0;

    uuid_v1_generator #(
        .TICK_LIMIT(TICK_LIMIT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .rsp    (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitors: sample both channels at the rising edge
    // ------------------------------------------------------------------------
    // every accepted request transfer gets its prediction queued
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            tracker.note_request(uv1_item_t'{mode:         req_ch.mode,
                                             time_reading: req_ch.time_reading,
                                             seed:         req_ch.seed});
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_result(uv1_result_t'{status:             rsp_ch.status,
                                               stamp_low:          rsp_ch.stamp_low,
                                               stamp_mid:          rsp_ch.stamp_mid,
                                               stamp_high_version: rsp_ch.stamp_high_version,
                                               seq_high_variant:   rsp_ch.seq_high_variant,
                                               seq_low:            rsp_ch.seq_low,
                                               node_out:           rsp_ch.node_out});
    end

    // ------------------------------------------------------------------------
    // receiver: random ready at the falling edge, with an optional long hold
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends a hung run
    // ------------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers: all called and returning at a falling edge
    // ------------------------------------------------------------------------
    // one request transfer, with random sender gaps in front of it
    task automatic send_item(logic [1:0] mode, logic [STAMP_W-1:0] reading,
                             logic [SEQ_W-1:0] seed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.time_reading <= reading;
        req_ch.seed         <= seed;
        cur_reading = reading;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // drop valid and wait until every due result has come out
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                              logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
        // setup phase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        // access phase
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // write node id while idle, mirror it, and read it back
    task automatic config_node(logic [NODE_W-1:0] value);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b1, NODE_ID_ADDR, APB_DATA_W'(value), rdata);
        tracker.node_id = value;
        apb_access(1'b0, NODE_ID_ADDR, '0, rdata);
        if (rdata !== APB_DATA_W'(value))
            tracker.report_mismatch($sformatf("node_id readback 0x%0h want 0x%0h",
                                              rdata, value));
    endtask

    function automatic logic [STAMP_W-1:0] rand_reading();
        return STAMP_W'({$urandom(), $urandom()});
    endfunction

    // readings cluster around the last one so repeats and backward steps happen
    function automatic logic [STAMP_W-1:0] pick_reading();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return cur_reading;
        else if (r < 60)
            return cur_reading + STAMP_W'($urandom_range(40, 1));
        else if (r < 75)
            return cur_reading - STAMP_W'($urandom_range(2000, 1));
        else if (r < 90)
            return rand_reading();
        else
            return MAX_READING - STAMP_W'($urandom_range(20));
    endfunction

    // mixed traffic: mostly generates, with inits, stamp sets and some noise
    task automatic run_mix(int unsigned count, int unsigned pause_at, int unsigned hold_at);
        int unsigned r;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n == hold_at)
                long_hold_req = 1'b1;
            if (n == pause_at)
                settle();
            r = $urandom_range(99);
            if (r < 55)
                send_item(MODE_GEN, pick_reading(), SEQ_W'($urandom_range(16383)));
            else if (r < 70)
                send_item(MODE_INIT, pick_reading(), SEQ_W'($urandom_range(16383)));
            else if (r < 85)
                send_item(MODE_SET, pick_reading(), SEQ_W'($urandom_range(16383)));
            else if (r < 88)
                send_item(MODE_UNDEF, rand_reading(), SEQ_W'($urandom_range(16383)));
            else
                send_item(MODE_GEN, rand_reading(), SEQ_W'($urandom_range(16383)));
        end
    endtask

    // one reading held long enough to run the per-tick counter dry
    task automatic run_tick_burst(int unsigned count);
        logic [STAMP_W-1:0] reading;
        reading = rand_reading();
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(14) == 0)
                send_item(MODE_INIT, reading, SEQ_W'($urandom_range(16383)));
            else
                send_item(MODE_GEN, reading, SEQ_W'($urandom_range(16383)));
        end
    endtask

    task automatic run_directed();
        // right after reset the counter sits at its limit on reading zero
        send_item(MODE_GEN, '0, '0);
        send_item(MODE_GEN, MAX_READING, 14'h3FFF);
        // repeat of the top reading wraps the stamp to zero, clock goes back
        send_item(MODE_GEN, MAX_READING, '0);
        send_item(MODE_INIT, 60'd5, 14'h3FFF);
        // backward step with sequence at its top wraps it
        send_item(MODE_GEN, 60'd3, '0);
        send_item(MODE_GEN, 60'd3, '0);
        send_item(MODE_SET, MAX_READING, '0);
        send_item(MODE_GEN, 60'd100, '0);
        send_item(MODE_UNDEF, 60'h555_5555_5555_5555, 14'h1555);
        send_item(MODE_INIT, 60'd100, 14'h2AAA);
        send_item(MODE_GEN, 60'h555_5555_5555_5555, 14'h1555);
        send_item(MODE_GEN, 60'hAAA_AAAA_AAAA_AAAA, 14'h2AAA);
        send_item(MODE_INIT, 60'hAAA_AAAA_AAAA_AAAA, 14'h1555);
        send_item(MODE_SET, '0, 14'h3FFF);
        send_item(MODE_GEN, '0, '0);
        send_item(MODE_UNDEF, MAX_READING, 14'h3FFF);
        send_item(MODE_GEN, 60'h800_0000_0000_0000, 14'h2AAA);
        send_item(MODE_SET, 60'h7FF_FFFF_FFFF_FFFF, 14'h1555);
        send_item(MODE_GEN, 60'h7FF_FFFF_FFFF_FFF0, '0);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [NODE_W-1:0] node_val;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_GEN;
        req_ch.time_reading = '0;
        req_ch.seed         = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // phase 0: slow receiver, mostly eager sender
        send_idle_pct = 19;
        recv_idle_pct = 86;
        config_node('1);
        run_directed();
        settle();

        node_val     = NODE_W'({$urandom(), $urandom()});
        node_val[40] = 1'b0;
        config_node(node_val);
        run_mix(190, '1, '1);
        run_tick_burst(1060);
        settle();

        // phase 1: slow sender, eager receiver, one full drain midway
        send_idle_pct = 86;
        recv_idle_pct = 19;
        config_node('0);
        run_mix(190, 100, '1);
        settle();

        // phase 2: no idling, one long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        node_val = NODE_W'({$urandom(), $urandom()});
        config_node(node_val);
        run_mix(190, '1, 30);
        settle();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
